// ===== rtl/kvtb_pkg.sv =====
// Shared types and constants for the key-value table with byte budget.
package kvtb_pkg;

  typedef enum logic [1:0] {
    REQ_SAVE   = 2'd0,
    REQ_LOAD   = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_OVER  = 2'd1,
    STAT_MISS  = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;
    logic exec_save;
    logic exec_clear;
    logic scan_start;
    logic step;
    logic miss;
    logic load_hit;
    logic del_hit;
    logic shift_wr;
    logic del_done;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_t req;
    logic cnt_zero;
    logic hit;
    logic last;
    logic shift_done;
  } sts_t;

  localparam logic [3:0]  MAX_LEN     = 4'd8;
  localparam logic [13:0] LIMIT_RESET = 14'd8192;
  localparam logic        LIMIT_IDX   = 1'b0;

endpackage

// ===== rtl/kvtb_ctrl.sv =====
// Request sequencer: accepts a request, runs save, clear, scan, compaction and result hand-off.
module kvtb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  kvtb_pkg::sts_t sts,
  output kvtb_pkg::cmd_t cmd
);

  kvtb_pkg::state_t state, state_next;
  logic             out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kvtb_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      kvtb_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap    = 1'b1;
          state_next = kvtb_pkg::S_EXEC;
        end
      end
      kvtb_pkg::S_EXEC: begin
        case (sts.req)
          kvtb_pkg::REQ_SAVE: begin
            cmd.exec_save = 1'b1;
            state_next    = kvtb_pkg::S_FIN;
          end
          kvtb_pkg::REQ_CLEAR: begin
            cmd.exec_clear = 1'b1;
            state_next     = kvtb_pkg::S_FIN;
          end
          default: begin
            if (sts.cnt_zero) begin
              cmd.miss   = 1'b1;
              state_next = kvtb_pkg::S_FIN;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = kvtb_pkg::S_SCAN;
            end
          end
        endcase
      end
      kvtb_pkg::S_SCAN: begin
        cmd.step = 1'b1;
        if (sts.hit) begin
          if (sts.req == kvtb_pkg::REQ_LOAD) begin
            cmd.load_hit = 1'b1;
            state_next   = kvtb_pkg::S_FIN;
          end else begin
            cmd.del_hit = 1'b1;
            state_next  = kvtb_pkg::S_SHIFT;
          end
        end else if (sts.last) begin
          cmd.miss   = 1'b1;
          state_next = kvtb_pkg::S_FIN;
        end
      end
      kvtb_pkg::S_SHIFT: begin
        if (sts.shift_done) begin
          cmd.del_done = 1'b1;
          state_next   = kvtb_pkg::S_FIN;
        end else begin
          cmd.step     = 1'b1;
          cmd.shift_wr = 1'b1;
        end
      end
      kvtb_pkg::S_FIN: begin
        // hold the result until the output register is free
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = kvtb_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = kvtb_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/kvtb_dp.sv =====
// Table datapath: entry memory, scan and compaction pointers, counters and result registers.
module kvtb_dp #(
  parameter int ENTRIES  = 1024,
  parameter int KEY_BITS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  kvtb_pkg::cmd_t cmd,
  output kvtb_pkg::sts_t sts,
  input  logic [13:0]    limit,
  input  logic [1:0]     req_type,
  input  logic [63:0]    key,
  input  logic [63:0]    value,
  input  logic [3:0]     value_len,
  output logic [1:0]     status,
  output logic [63:0]    found_value,
  output logic [3:0]     found_len,
  output logic [10:0]    entry_count,
  output logic [13:0]    bytes_used
);

  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW      = $clog2(ENTRIES + 1);
  localparam int ENTRY_W = KEY_BITS + 64 + 4;

  logic [ENTRY_W-1:0]  mem [ENTRIES];
  logic [ENTRY_W-1:0]  rd_word;
  logic [KEY_BITS-1:0] rd_key;
  logic [63:0]         rd_val;
  logic [3:0]          rd_len;

  kvtb_pkg::req_t      req;
  logic [KEY_BITS-1:0] req_key;
  logic [63:0]         req_val;
  logic [3:0]          req_len;

  logic [CW-1:0]       count;
  logic [13:0]         used;
  logic [CW-1:0]       rd_ptr;
  logic [CW-1:0]       wr_ptr;
  logic [CW-1:0]       idx;
  logic                rv;

  kvtb_pkg::status_t   res_status;
  logic [63:0]         res_val;
  logic [3:0]          res_len;

  logic [14:0]         sum;
  logic                over;
  logic                full;
  logic                save_ok;
  logic                rd_more;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [ENTRY_W-1:0]  mem_wd;
  logic [CW+10:0]      cnt_ext;

  assign rd_key = rd_word[ENTRY_W-1 -: KEY_BITS];
  assign rd_val = rd_word[67:4];
  assign rd_len = rd_word[3:0];

  assign sum     = {1'b0, used} + {11'd0, req_len};
  assign over    = sum > {1'b0, limit};
  assign full    = count == CW'(ENTRIES);
  assign save_ok = cmd.exec_save && !over && !full;
  assign rd_more = rd_ptr < count;

  assign sts.req        = req;
  assign sts.cnt_zero   = count == '0;
  assign sts.hit        = rv && (rd_key == req_key);
  assign sts.last       = rv && (idx == count - CW'(1));
  assign sts.shift_done = !rd_more && !rv;

  // Write port: appended entry on a save, otherwise the next entry moved down.
  always_comb begin
    mem_we = save_ok || (cmd.shift_wr && rv);
    if (save_ok) begin
      mem_wa = count[AW-1:0];
      mem_wd = {req_key, req_val, req_len};
    end else begin
      mem_wa = wr_ptr[AW-1:0];
      mem_wd = rd_word;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_word <= mem[rd_ptr[AW-1:0]];
  end

  // Request capture and result registers.
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req        <= kvtb_pkg::req_t'(req_type);
      req_key    <= key[KEY_BITS-1:0];
      req_val    <= value;
      req_len    <= (value_len > kvtb_pkg::MAX_LEN) ? kvtb_pkg::MAX_LEN : value_len;
      res_status <= kvtb_pkg::STAT_OK;
      res_val    <= '0;
      res_len    <= '0;
    end else if (cmd.exec_save) begin
      if (over) begin
        res_status <= kvtb_pkg::STAT_OVER;
      end else if (full) begin
        res_status <= kvtb_pkg::STAT_FULL;
      end
    end else if (cmd.miss) begin
      res_status <= kvtb_pkg::STAT_MISS;
    end else if (cmd.load_hit) begin
      res_val <= rd_val;
      res_len <= rd_len;
    end
  end

  assign cnt_ext = {11'd0, count};

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status      <= res_status;
      found_value <= res_val;
      found_len   <= res_len;
      entry_count <= cnt_ext[10:0];
      bytes_used  <= used;
    end
  end

  // Table occupancy and pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      used   <= '0;
      rd_ptr <= '0;
      wr_ptr <= '0;
      idx    <= '0;
      rv     <= 1'b0;
    end else begin
      if (save_ok) begin
        count <= count + CW'(1);
        used  <= sum[13:0];
      end else if (cmd.exec_clear) begin
        count <= '0;
        used  <= '0;
      end else if (cmd.del_hit) begin
        used <= (used >= {10'd0, rd_len}) ? used - {10'd0, rd_len} : '0;
      end else if (cmd.del_done) begin
        count <= count - CW'(1);
      end

      if (cmd.scan_start) begin
        rd_ptr <= '0;
        rv     <= 1'b0;
      end else if (cmd.del_hit) begin
        // restart reads just past the match; writes land on the match
        rd_ptr <= idx + CW'(1);
        wr_ptr <= idx;
        rv     <= 1'b0;
      end else if (cmd.step) begin
        rd_ptr <= rd_ptr + CW'(rd_more);
        idx    <= rd_ptr;
        rv     <= rd_more;
        if (cmd.shift_wr && rv) begin
          wr_ptr <= wr_ptr + CW'(1);
        end
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRIES))
    else $error("entry count above table size");

  a_empty_no_bytes: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (used == '0))
    else $error("bytes held by an empty table");

  a_shift_order: assert property (@(posedge clk) disable iff (rst)
    (cmd.shift_wr && rv) |-> (wr_ptr < rd_ptr) && (wr_ptr < count))
    else $error("compaction write not behind read");

  a_save_fits: assert property (@(posedge clk) disable iff (rst)
    save_ok |=> (count != '0) && (used <= limit))
    else $error("accepted save broke the budget");

endmodule

// ===== rtl/key_value_table_with_budget.sv =====
// Key-value table with byte budget: one request at a time, linear key search.
// Save and clear pass from acceptance through the execute and finish states to the registered result.
// Load scans the memory one entry per cycle until the key matches or the last entry is passed.
// Delete scans to the match, then moves each later entry down one per cycle.
// The next request is taken only once the result of the last one is registered.
// Reset clears count, bytes in use and control and sets memory_limit to 8192; entries stay.
module key_value_table_with_budget #(
  parameter int ENTRIES  = 1024,
  parameter int KEY_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [63:0] key,
  input  logic [63:0] value,
  input  logic [3:0]  value_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [63:0] found_value,
  output logic [3:0]  found_len,
  output logic [10:0] entry_count,
  output logic [13:0] bytes_used
);

  logic [13:0]    limit;
  logic           limit_sel;
  kvtb_pkg::cmd_t cmd;
  kvtb_pkg::sts_t sts;

  assign pready    = 1'b1;
  assign limit_sel = paddr[2] == kvtb_pkg::LIMIT_IDX;
  assign prdata    = limit_sel ? {18'd0, limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= kvtb_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && limit_sel) begin
      limit <= pwdata[13:0];
    end
  end

  kvtb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kvtb_dp #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .limit       (limit),
    .req_type    (req_type),
    .key         (key),
    .value       (value),
    .value_len   (value_len),
    .status      (status),
    .found_value (found_value),
    .found_len   (found_len),
    .entry_count (entry_count),
    .bytes_used  (bytes_used)
  );

endmodule

// ===== tb/key_value_table_with_budget_tb.sv =====
// Testbench for the key-value table with byte budget: directed rows, random traffic, scoreboard.
`timescale 1ns / 1ps

module key_value_table_with_budget_tb;

  localparam int TABLE_DEPTH = 1024;
  localparam int ROW_CAP     = 48;
  localparam int LONG_HOLD   = 400;
  localparam int TIMEOUT_NS  = 10_000_000;
  localparam int DIR_ROWS    = 30;
  localparam int FILL_ROWS   = 25;

  localparam logic [63:0] K_ONES = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] K_A    = 64'ha5a5_5a5a_0f0f_f0f0;
  localparam logic [63:0] V_A    = 64'h0123_4567_89ab_cdef;
  localparam logic [63:0] V_B    = 64'h8000_0000_0000_0001;

  typedef struct packed {
    kvtb_pkg::status_t stat;
    logic [63:0]       fval;
    logic [3:0]        flen;
    logic [10:0]       cnt;
    logic [13:0]       bytes;
  } reply_t;

  typedef struct packed {
    logic           set_lim;
    logic [13:0]    lim_val;
    kvtb_pkg::req_t req;
    logic [63:0]    key;
    logic [63:0]    val;
    logic [3:0]     len;
    logic           typed;
    reply_t         exp;
  } dir_row_t;

  localparam reply_t NO_REPLY = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = '0;
  logic [63:0] key = '0;
  logic [63:0] value = '0;
  logic [3:0]  value_len = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [63:0] found_value;
  logic [3:0]  found_len;
  logic [10:0] entry_count;
  logic [13:0] bytes_used;

  // Shadow of the table contents and budget
  logic [63:0] tbl_key [TABLE_DEPTH];
  logic [63:0] tbl_val [TABLE_DEPTH];
  logic [3:0]  tbl_len [TABLE_DEPTH];
  int          tbl_count = 0;
  int          tbl_bytes = 0;
  int          mem_limit = int'(kvtb_pkg::LIMIT_RESET);

  reply_t      awaited_replies [$];
  int          errors = 0;
  int          n_requests = 0;
  int          replies_seen = 0;
  int          stat_seen [4] = '{0, 0, 0, 0};
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  int          hold_asks = 0;
  int          hold_done = 0;

  dir_row_t directed_rows [DIR_ROWS] = '{
    '{0, 0, kvtb_pkg::REQ_LOAD, 64'd0, 64'd0, 4'd0, 1,
      '{kvtb_pkg::STAT_MISS, 64'd0, 4'd0, 11'd0, 14'd0}},
    '{0, 0, kvtb_pkg::REQ_DELETE, K_ONES, 64'd0, 4'd0, 1,
      '{kvtb_pkg::STAT_MISS, 64'd0, 4'd0, 11'd0, 14'd0}},
    '{0, 0, kvtb_pkg::REQ_SAVE, 64'd0, 64'd0, 4'd0, 1,
      '{kvtb_pkg::STAT_OK, 64'd0, 4'd0, 11'd1, 14'd0}},
    '{0, 0, kvtb_pkg::REQ_SAVE, K_ONES, K_ONES, 4'd8, 1,
      '{kvtb_pkg::STAT_OK, 64'd0, 4'd0, 11'd2, 14'd8}},
    '{0, 0, kvtb_pkg::REQ_SAVE, K_A, V_A, 4'd15, 1,
      '{kvtb_pkg::STAT_OK, 64'd0, 4'd0, 11'd3, 14'd16}},
    '{0, 0, kvtb_pkg::REQ_LOAD, K_A, 64'd0, 4'd0, 1,
      '{kvtb_pkg::STAT_OK, V_A, 4'd8, 11'd3, 14'd16}},
    '{0, 0, kvtb_pkg::REQ_LOAD, K_ONES, 64'd0, 4'd0, 1,
      '{kvtb_pkg::STAT_OK, K_ONES, 4'd8, 11'd3, 14'd16}},
    '{0, 0, kvtb_pkg::REQ_SAVE, K_A, V_B, 4'd3, 1,
      '{kvtb_pkg::STAT_OK, 64'd0, 4'd0, 11'd4, 14'd19}},
    '{0, 0, kvtb_pkg::REQ_LOAD, K_A, 64'd0, 4'd0, 1,
      '{kvtb_pkg::STAT_OK, V_A, 4'd8, 11'd4, 14'd19}},
    '{0, 0, kvtb_pkg::REQ_DELETE, K_A, 64'd0, 4'd0, 1,
      '{kvtb_pkg::STAT_OK, 64'd0, 4'd0, 11'd3, 14'd11}},
    '{0, 0, kvtb_pkg::REQ_LOAD, K_A, 64'd0, 4'd0, 1,
      '{kvtb_pkg::STAT_OK, V_B, 4'd3, 11'd3, 14'd11}},
    '{0, 0, kvtb_pkg::REQ_LOAD, 64'd0, K_ONES, 4'd0, 1,
      '{kvtb_pkg::STAT_OK, 64'd0, 4'd0, 11'd3, 14'd11}},
    '{0, 0, kvtb_pkg::REQ_DELETE, 64'd0, 64'd0, 4'd0, 1,
      '{kvtb_pkg::STAT_OK, 64'd0, 4'd0, 11'd2, 14'd11}},
    '{0, 0, kvtb_pkg::REQ_SAVE, 64'd1, V_A, 4'd9, 1,
      '{kvtb_pkg::STAT_OK, 64'd0, 4'd0, 11'd3, 14'd19}},
    '{0, 0, kvtb_pkg::REQ_LOAD, 64'd1, 64'd0, 4'd0, 0, NO_REPLY},
    '{0, 0, kvtb_pkg::REQ_CLEAR, K_A, V_A, 4'd7, 1,
      '{kvtb_pkg::STAT_OK, 64'd0, 4'd0, 11'd0, 14'd0}},
    '{0, 0, kvtb_pkg::REQ_LOAD, K_ONES, 64'd0, 4'd0, 1,
      '{kvtb_pkg::STAT_MISS, 64'd0, 4'd0, 11'd0, 14'd0}},
    '{0, 0, kvtb_pkg::REQ_CLEAR, 64'd0, 64'd0, 4'd0, 1,
      '{kvtb_pkg::STAT_OK, 64'd0, 4'd0, 11'd0, 14'd0}},
    '{1, 14'd0, kvtb_pkg::REQ_CLEAR, 64'd0, 64'd0, 4'd0, 0, NO_REPLY},
    '{0, 0, kvtb_pkg::REQ_SAVE, 64'd1, V_A, 4'd1, 1,
      '{kvtb_pkg::STAT_OVER, 64'd0, 4'd0, 11'd0, 14'd0}},
    '{0, 0, kvtb_pkg::REQ_SAVE, 64'd1, V_A, 4'd0, 1,
      '{kvtb_pkg::STAT_OK, 64'd0, 4'd0, 11'd1, 14'd0}},
    '{1, 14'd5, kvtb_pkg::REQ_CLEAR, 64'd0, 64'd0, 4'd0, 0, NO_REPLY},
    '{0, 0, kvtb_pkg::REQ_SAVE, 64'd2, V_B, 4'd5, 1,
      '{kvtb_pkg::STAT_OK, 64'd0, 4'd0, 11'd2, 14'd5}},
    '{0, 0, kvtb_pkg::REQ_SAVE, 64'd3, V_A, 4'd1, 1,
      '{kvtb_pkg::STAT_OVER, 64'd0, 4'd0, 11'd2, 14'd5}},
    '{1, 14'd2, kvtb_pkg::REQ_CLEAR, 64'd0, 64'd0, 4'd0, 0, NO_REPLY},
    '{0, 0, kvtb_pkg::REQ_SAVE, 64'd3, V_A, 4'd0, 1,
      '{kvtb_pkg::STAT_OVER, 64'd0, 4'd0, 11'd2, 14'd5}},
    '{0, 0, kvtb_pkg::REQ_DELETE, 64'd2, 64'd0, 4'd0, 1,
      '{kvtb_pkg::STAT_OK, 64'd0, 4'd0, 11'd1, 14'd0}},
    '{0, 0, kvtb_pkg::REQ_SAVE, 64'd3, V_A, 4'd2, 0, NO_REPLY},
    '{1, 14'd8192, kvtb_pkg::REQ_CLEAR, 64'd0, 64'd0, 4'd0, 0, NO_REPLY},
    '{0, 0, kvtb_pkg::REQ_CLEAR, 64'd0, 64'd0, 4'd0, 1,
      '{kvtb_pkg::STAT_OK, 64'd0, 4'd0, 11'd0, 14'd0}}
  };

  key_value_table_with_budget u_top (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .key         (key),
    .value       (value),
    .value_len   (value_len),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found_value (found_value),
    .found_len   (found_len),
    .entry_count (entry_count),
    .bytes_used  (bytes_used)
  );

  always #6 clk = ~clk;

  // Apply one request to the shadow table and return the reply it should give
  function automatic reply_t apply_to_table(kvtb_pkg::req_t rq, logic [63:0] k,
                                            logic [63:0] v, logic [3:0] ln);
    reply_t r;
    logic [3:0] eff_len;
    int pos;
    r = NO_REPLY;
    r.stat = kvtb_pkg::STAT_OK;
    eff_len = (ln > kvtb_pkg::MAX_LEN) ? kvtb_pkg::MAX_LEN : ln;
    pos = -1;
    if (rq == kvtb_pkg::REQ_LOAD || rq == kvtb_pkg::REQ_DELETE) begin
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_key[i] == k) begin
          pos = i;
          break;
        end
      end
    end
    case (rq)
      kvtb_pkg::REQ_SAVE: begin
        if (tbl_bytes + int'(eff_len) > mem_limit) begin
          r.stat = kvtb_pkg::STAT_OVER;
        end else if (tbl_count >= TABLE_DEPTH) begin
          r.stat = kvtb_pkg::STAT_FULL;
        end else begin
          tbl_key[tbl_count] = k;
          tbl_val[tbl_count] = v;
          tbl_len[tbl_count] = eff_len;
          tbl_count++;
          tbl_bytes += int'(eff_len);
        end
      end
      kvtb_pkg::REQ_LOAD: begin
        if (pos < 0) begin
          r.stat = kvtb_pkg::STAT_MISS;
        end else begin
          r.fval = tbl_val[pos];
          r.flen = tbl_len[pos];
        end
      end
      kvtb_pkg::REQ_DELETE: begin
        if (pos < 0) begin
          r.stat = kvtb_pkg::STAT_MISS;
        end else begin
          tbl_bytes = (tbl_bytes >= int'(tbl_len[pos])) ? tbl_bytes - int'(tbl_len[pos]) : 0;
          // compact later entries down one place
          for (int i = pos; i + 1 < tbl_count; i++) begin
            tbl_key[i] = tbl_key[i + 1];
            tbl_val[i] = tbl_val[i + 1];
            tbl_len[i] = tbl_len[i + 1];
          end
          tbl_count--;
        end
      end
      default: begin
        tbl_count = 0;
        tbl_bytes = 0;
      end
    endcase
    r.cnt   = 11'(tbl_count);
    r.bytes = 14'(tbl_bytes);
    return r;
  endfunction

  // Half keys already stored, a quarter from a small shared set, the rest fully random
  function automatic logic [63:0] pick_key();
    case ($urandom_range(0, 3))
      0, 1: begin
        if (tbl_count > 0) return tbl_key[$urandom_range(0, tbl_count - 1)];
        return {$urandom, $urandom};
      end
      2: return 64'($urandom_range(0, 7)) * 64'h1111_1111_1111_1111;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic issue_request(input kvtb_pkg::req_t rq, input logic [63:0] k,
                               input logic [63:0] v, input logic [3:0] ln,
                               input logic typed, input reply_t given);
    reply_t want;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= rq;
    key       <= k;
    value     <= v;
    value_len <= ln;
    do @(posedge clk); while (!in_ready);
    want = apply_to_table(rq, k, v, ln);
    if (typed) want = given;
    awaited_replies.push_back(want);
    n_requests++;
  endtask

  task automatic wait_replies();
    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [13:0] lim);
    wait_replies();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {kvtb_pkg::LIMIT_IDX, 2'b00};
    pwdata  <= 32'(lim);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    mem_limit = int'(lim);
  endtask

  // cap > 0 keeps the table short so scans stay cheap
  task automatic random_traffic(input int n, input int cap);
    kvtb_pkg::req_t rq;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) rq = kvtb_pkg::REQ_SAVE;
      else if (pick < 65) rq = kvtb_pkg::REQ_LOAD;
      else if (pick < 96) rq = kvtb_pkg::REQ_DELETE;
      else rq = kvtb_pkg::REQ_CLEAR;
      if (cap > 0 && tbl_count >= cap && rq == kvtb_pkg::REQ_SAVE)
        rq = ($urandom_range(0, 3) == 0) ? kvtb_pkg::REQ_CLEAR : kvtb_pkg::REQ_DELETE;
      issue_request(rq, pick_key(), {$urandom, $urandom}, 4'($urandom_range(0, 15)),
                    1'b0, NO_REPLY);
    end
  endtask

  // Receiver: random short stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_asks != hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = hold_asks;
        out_ready <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && out_ready) begin
      replies_seen++;
      stat_seen[status]++;
      if (awaited_replies.size() == 0) begin
        $error("reply with no request waiting: status %0d", status);
        errors++;
      end else begin
        want = awaited_replies.pop_front();
        if (status !== want.stat) begin
          $error("status: expected %0d, got %0d", want.stat, status);
          errors++;
        end
        if (found_value !== want.fval) begin
          $error("found_value: expected %h, got %h", want.fval, found_value);
          errors++;
        end
        if (found_len !== want.flen) begin
          $error("found_len: expected %0d, got %0d", want.flen, found_len);
          errors++;
        end
        if (entry_count !== want.cnt) begin
          $error("entry_count: expected %0d, got %0d", want.cnt, entry_count);
          errors++;
        end
        if (bytes_used !== want.bytes) begin
          $error("bytes_used: expected %0d, got %0d", want.bytes, bytes_used);
          errors++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_lim)
        write_limit(directed_rows[i].lim_val);
      else
        issue_request(directed_rows[i].req, directed_rows[i].key, directed_rows[i].val,
                      directed_rows[i].len, directed_rows[i].typed, directed_rows[i].exp);
    end

    // Full budget: long receiver hold-off midway, then a full drain
    random_traffic(75, ROW_CAP);
    hold_asks++;
    random_traffic(40, ROW_CAP);
    wait_replies();
    random_traffic(35, ROW_CAP);

    write_limit(14'($urandom_range(16, 64)));
    random_traffic(150, ROW_CAP);

    // Fill a small budget to the byte: every save charges eight bytes
    write_limit(14'(FILL_ROWS * 8));
    issue_request(kvtb_pkg::REQ_CLEAR, 64'd0, 64'd0, 4'd0, 1'b0, NO_REPLY);
    for (int i = 0; i < FILL_ROWS; i++)
      issue_request(kvtb_pkg::REQ_SAVE, pick_key(), {$urandom, $urandom},
                    4'($urandom_range(8, 15)), 1'b0, NO_REPLY);
    issue_request(kvtb_pkg::REQ_SAVE, K_A, V_A, 4'd1, 1'b1,
                  '{kvtb_pkg::STAT_OVER, 64'd0, 4'd0, 11'(FILL_ROWS), 14'(FILL_ROWS * 8)});
    issue_request(kvtb_pkg::REQ_SAVE, K_A, V_A, 4'd0, 1'b1,
                  '{kvtb_pkg::STAT_OK, 64'd0, 4'd0, 11'(FILL_ROWS + 1), 14'(FILL_ROWS * 8)});
    issue_request(kvtb_pkg::REQ_DELETE, tbl_key[0], 64'd0, 4'd0, 1'b0, NO_REPLY);
    random_traffic(20, 0);
    issue_request(kvtb_pkg::REQ_CLEAR, 64'd0, 64'd0, 4'd0, 1'b0, NO_REPLY);

    write_limit(14'd0);
    random_traffic(60, ROW_CAP);

    // Last stretch runs with no idling on either side
    write_limit(14'd8192);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    random_traffic(150, ROW_CAP);

    wait_replies();
    repeat (20) @(posedge clk);

    $display("Sent %0d table requests through budgets 0 to 8192, one filled to the last byte.",
             n_requests);
    $display("Replies: %0d (ok %0d, over budget %0d, not found %0d, full %0d), %0d errors.",
             replies_seen, stat_seen[0], stat_seen[1], stat_seen[2], stat_seen[3], errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/kvtb_pkg.sv
rtl/kvtb_ctrl.sv
rtl/kvtb_dp.sv
rtl/key_value_table_with_budget.sv
tb/key_value_table_with_budget_tb.sv
